[hdl/pfca_pkg.sv]
// Shared widths, constants and control bundles for the pressure frame CRC average block.
package pfca_pkg;

  // Moving average history depth
  localparam int unsigned WINDOW_MAX = 16;
  localparam int unsigned SLOT_W     = $clog2(WINDOW_MAX);
  localparam int unsigned FILL_W     = $clog2(WINDOW_MAX + 1);

  // Ring samples and running sums (temperature sample is the widest)
  localparam int unsigned SAMPLE_W   = 17;
  localparam int unsigned SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
  // Pressure sample magnitude stays at or below 546
  localparam int unsigned PMAG_W     = 10;
  localparam int unsigned PSUM_MAG_W = PMAG_W + $clog2(WINDOW_MAX);

  // Numerator widths of the four divisions
  localparam int unsigned P_AVG_SHIFT   = 9;  // * 256 for Q8, * 2 for rounding
  localparam int unsigned T_SCALE_SHIFT = 6;  // * 32, * 2 for rounding
  localparam int unsigned PSCALE_NUM_W  = 18;
  localparam int unsigned TSCALE_NUM_W  = 16 + T_SCALE_SHIFT + 1;
  localparam int unsigned PAVG_NUM_W    = PSUM_MAG_W + P_AVG_SHIFT + 1;
  localparam int unsigned TAVG_NUM_W    = SUM_W + 2;
  localparam int unsigned NUM_A_W = (PSCALE_NUM_W > TSCALE_NUM_W) ? PSCALE_NUM_W : TSCALE_NUM_W;
  localparam int unsigned NUM_B_W = (PAVG_NUM_W > TAVG_NUM_W) ? PAVG_NUM_W : TAVG_NUM_W;
  localparam int unsigned DIV_RAW_W = (NUM_A_W > NUM_B_W) ? NUM_A_W : NUM_B_W;
  // Two quotient bits per step, so keep the width even
  localparam int unsigned DIV_W     = DIV_RAW_W + (DIV_RAW_W % 2);
  localparam int unsigned DIV_STEPS = DIV_W / 2;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  // Divisor: 480 at most for pressure scaling, 2 * fill for averages
  localparam int unsigned DEN_W     = (FILL_W + 1 > 9) ? FILL_W + 1 : 9;

  // Result widths
  localparam int unsigned PRESS_Q8_W = 19;
  localparam int unsigned TEMP_Q8_W  = 17;

  // CRC-8 of each word
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [3:0] MIN_FRAME_BYTES = 4'd6;

  // Scaling divisors
  localparam logic [7:0] P_DIV_FINE    = 8'd60;
  localparam logic [7:0] P_DIV_COARSE  = 8'd240;
  localparam logic [7:0] T_SCALE_BIAS  = 8'd25;
  localparam logic [7:0] T_SCALE_DEN   = 8'd50;

  // Configuration port
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PWIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TWIN  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUS_FAIL = 2'd1,
    STATUS_SHORT    = 2'd2
  } status_e;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic [FILL_W-1:0] window;
  } ring_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

endpackage

[hdl/pfca_div.sv]
// Shared restoring divider, two quotient bits per cycle.
module pfca_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pfca_pkg::div_req_t       req_i,
  output logic                     done_o,
  output logic [pfca_pkg::DIV_W-1:0] quot_o
);
  import pfca_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;

  logic [DEN_W:0] r1, r1n, r2, r2n;
  logic           b1, b2;

  always_comb begin
    r1  = {rem_q, num_q[DIV_W-1]};
    b1  = (r1 >= {1'b0, den_q});
    r1n = b1 ? (r1 - {1'b0, den_q}) : r1;
    r2  = {r1n[DEN_W-1:0], num_q[DIV_W-2]};
    b2  = (r2 >= {1'b0, den_q});
    r2n = b2 ? (r2 - {1'b0, den_q}) : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == CNT_W'(DIV_STEPS - 1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Numerator bits shift out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-3:0], b1, b2};
      rem_q <= r2n[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

[hdl/pfca_ring.sv]
// One channel's sample history, running sum, fill count and write slot.
module pfca_ring (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfca_pkg::ring_ctrl_t                ctrl_i,
  input  logic signed [pfca_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [pfca_pkg::SUM_W-1:0]    sum_o,
  output logic [pfca_pkg::FILL_W-1:0]          fill_o
);
  import pfca_pkg::*;

  logic signed [SAMPLE_W-1:0] ring_q [WINDOW_MAX];
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [SLOT_W-1:0]          slot_q, slot_d;

  logic [SLOT_W-1:0]          wr_slot;
  logic [FILL_W-1:0]          slot_inc;
  logic                       full;
  logic signed [SAMPLE_W-1:0] oldest;

  always_comb begin
    wr_slot  = (FILL_W'(slot_q) >= ctrl_i.window) ? '0 : slot_q;
    full     = (fill_q >= ctrl_i.window);
    oldest   = ring_q[wr_slot];
    sum_d    = sum_q + SUM_W'(sample_i) - (full ? SUM_W'(oldest) : SUM_W'(0));
    fill_d   = full ? fill_q : fill_q + FILL_W'(1);
    slot_inc = FILL_W'(wr_slot) + FILL_W'(1);
    slot_d   = (slot_inc == ctrl_i.window) ? '0 : slot_inc[SLOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      slot_q <= '0;
    end else if (ctrl_i.clear) begin
      sum_q  <= '0;
      fill_q <= '0;
      slot_q <= '0;
    end else if (ctrl_i.push) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      ring_q[wr_slot] <= sample_i;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

[hdl/pressure_frame_crc_average.sv]
// A rejected frame (bus fail, short frame or no CRC match) goes from CRC_HI and CRC_LO
// straight to RESULT; each division adds a load, 12 two-bit divider steps and done, and
// a frame with both words good runs four divisions. Frames are taken one at a time: the
// next is accepted in the cycle after the result is registered, later while a stalled
// result holds the output register. Reset clears the sequencer, sums, fill counts, slots,
// held values; range_q = 1, windows = 1.
module pressure_frame_crc_average (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [pfca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfca_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input frame channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 read_ok_i,
  input  logic [3:0]                           byte_count_i,
  input  logic [7:0]                           press_high_i,
  input  logic [7:0]                           press_low_i,
  input  logic [7:0]                           press_check_i,
  input  logic [7:0]                           temp_high_i,
  input  logic [7:0]                           temp_low_i,
  input  logic [7:0]                           temp_check_i,
  // Result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic                                 press_crc_good_o,
  output logic                                 temp_crc_good_o,
  output logic signed [pfca_pkg::PRESS_Q8_W-1:0] pressure_q8_o,
  output logic signed [pfca_pkg::TEMP_Q8_W-1:0]  temperature_q8_o
);
  import pfca_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    CRC_HI,
    CRC_LO,
    P_SCALE_GO,
    P_SCALE_WAIT,
    P_AVG_GO,
    P_AVG_WAIT,
    T_SCALE_GO,
    T_SCALE_WAIT,
    T_AVG_GO,
    T_AVG_WAIT,
    RESULT
  } state_e;

  // One CRC-8 byte update, MSB first
  function automatic logic [7:0] crc8_byte(logic [7:0] c_in, logic [7:0] data);
    logic [7:0] c;
    c = c_in ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Zero acts as one, anything above the history depth acts as the depth
  function automatic logic [FILL_W-1:0] clamp_window(logic [CFG_W-1:0] v);
    logic [FILL_W-1:0] w;
    if (v == '0) begin
      w = FILL_W'(1);
    end else if (32'(v) > WINDOW_MAX) begin
      w = FILL_W'(WINDOW_MAX);
    end else begin
      w = FILL_W'(v);
    end
    return w;
  endfunction

  state_e state_q;

  // Configuration registers
  logic              range_q;
  logic [FILL_W-1:0] p_win_q;
  logic [FILL_W-1:0] t_win_q;

  // Latched frame
  status_e    st_q;
  logic [7:0] ph_q, pl_q, pc_q, th_q, tl_q, tc_q;
  logic [7:0] crc_p_q, crc_t_q;

  logic pgood_q, tgood_q;
  logic neg_q;
  logic signed [PRESS_Q8_W-1:0] held_p_q;
  logic signed [TEMP_Q8_W-1:0]  held_t_q;

  // Result register
  logic                         out_valid_q;
  status_e                      out_status_q;
  logic                         out_pgood_q, out_tgood_q;
  logic signed [PRESS_Q8_W-1:0] out_press_q;
  logic signed [TEMP_Q8_W-1:0]  out_temp_q;

  logic in_take;
  logic p_match, t_match;

  // Divider and rings
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  logic [DIV_W-1:0] q_sgn;

  ring_ctrl_t                p_ctrl, t_ctrl;
  logic signed [SUM_W-1:0]   p_sum, t_sum;
  logic [FILL_W-1:0]         p_fill, t_fill;
  logic [SUM_W-1:0]          p_sum_mag, t_sum_mag;
  logic signed [16:0]        p_word, t_word;
  logic [16:0]               p_word_mag, t_word_mag;
  logic [7:0]                p_div;

  assign in_stall_o = (state_q != IDLE);
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration: range select and windows; a window write also clears its ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= 1'b1;
      p_win_q <= FILL_W'(1);
      t_win_q <= FILL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RANGE: range_q <= cfg_wdata_i[0];
        REG_PWIN:  p_win_q <= clamp_window(cfg_wdata_i);
        REG_TWIN:  t_win_q <= clamp_window(cfg_wdata_i);
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Latch the frame on acceptance and run the two CRC bytes
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ph_q <= press_high_i;
      pl_q <= press_low_i;
      pc_q <= press_check_i;
      th_q <= temp_high_i;
      tl_q <= temp_low_i;
      tc_q <= temp_check_i;
      priority if (!read_ok_i) begin
        st_q <= STATUS_BUS_FAIL;
      end else if (byte_count_i < MIN_FRAME_BYTES) begin
        st_q <= STATUS_SHORT;
      end else begin
        st_q <= STATUS_OK;
      end
    end
    if (state_q == CRC_HI) begin
      crc_p_q <= crc8_byte(CRC_INIT, ph_q);
      crc_t_q <= crc8_byte(CRC_INIT, th_q);
    end
  end

  // Finish the CRC with the low byte; a bad frame never counts as a match
  assign p_match = (st_q == STATUS_OK) && (crc8_byte(crc_p_q, pl_q) == pc_q);
  assign t_match = (st_q == STATUS_OK) && (crc8_byte(crc_t_q, tl_q) == tc_q);

  // Operand magnitudes; the divider works on magnitudes, the sign is applied after
  always_comb begin
    p_word     = {ph_q[7], ph_q, pl_q};
    t_word     = {th_q[7], th_q, tl_q};
    p_word_mag = p_word[16] ? 17'(-p_word) : 17'(p_word);
    t_word_mag = t_word[16] ? 17'(-t_word) : 17'(t_word);
    p_sum_mag  = p_sum[SUM_W-1] ? SUM_W'(-p_sum) : SUM_W'(p_sum);
    t_sum_mag  = t_sum[SUM_W-1] ? SUM_W'(-t_sum) : SUM_W'(t_sum);
    p_div      = range_q ? P_DIV_COARSE : P_DIV_FINE;
  end

  // Divider request: every rounding division is (2 * |n| + d) / (2 * d)
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_q)
      P_SCALE_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({p_word_mag, 1'b0}) + DIV_W'(p_div);
        div_req.den   = DEN_W'({p_div, 1'b0});
      end
      P_AVG_GO: begin
        // Pressure average comes out in Q8: numerator carries the extra * 256
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({p_sum_mag[PSUM_MAG_W-1:0], P_AVG_SHIFT'(0)})
                      + DIV_W'(p_fill);
        div_req.den   = DEN_W'({p_fill, 1'b0});
      end
      T_SCALE_GO: begin
        // raw * 256 / 200 is raw * 32 / 25
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({t_word_mag, T_SCALE_SHIFT'(0)}) + DIV_W'(T_SCALE_BIAS);
        div_req.den   = DEN_W'(T_SCALE_DEN);
      end
      T_AVG_GO: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({t_sum_mag, 1'b0}) + DIV_W'(t_fill);
        div_req.den   = DEN_W'({t_fill, 1'b0});
      end
      default: ;
    endcase
  end

  assign q_sgn = neg_q ? (DIV_W'(0) - div_quot) : div_quot;

  pfca_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Push the scaled sample as soon as the divider hands it back
  always_comb begin
    p_ctrl.clear  = cfg_we_i && (cfg_index_i == REG_PWIN);
    p_ctrl.push   = (state_q == P_SCALE_WAIT) && div_done;
    p_ctrl.window = p_win_q;
    t_ctrl.clear  = cfg_we_i && (cfg_index_i == REG_TWIN);
    t_ctrl.push   = (state_q == T_SCALE_WAIT) && div_done;
    t_ctrl.window = t_win_q;
  end

  pfca_ring u_press_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (p_ctrl),
    .sample_i (signed'(q_sgn[SAMPLE_W-1:0])),
    .sum_o    (p_sum),
    .fill_o   (p_fill)
  );

  pfca_ring u_temp_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (t_ctrl),
    .sample_i (signed'(q_sgn[SAMPLE_W-1:0])),
    .sum_o    (t_sum),
    .fill_o   (t_fill)
  );

  // Sequencer: CRC, pressure then temperature scale and average on CRC match, then result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      pgood_q      <= 1'b0;
      tgood_q      <= 1'b0;
      neg_q        <= 1'b0;
      held_p_q     <= '0;
      held_t_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_pgood_q  <= 1'b0;
      out_tgood_q  <= 1'b0;
      out_press_q  <= '0;
      out_temp_q   <= '0;
    end else begin
      // Drop the result once it has been taken, unless a new one replaces it
      if (out_valid_q && !out_stall_i && (state_q != RESULT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            state_q <= CRC_HI;
          end
        end
        CRC_HI: begin
          state_q <= CRC_LO;
        end
        CRC_LO: begin
          pgood_q <= p_match;
          tgood_q <= t_match;
          priority if (p_match) begin
            state_q <= P_SCALE_GO;
          end else if (t_match) begin
            state_q <= T_SCALE_GO;
          end else begin
            state_q <= RESULT;
          end
        end
        P_SCALE_GO: begin
          neg_q   <= p_word[16];
          state_q <= P_SCALE_WAIT;
        end
        P_SCALE_WAIT: begin
          if (div_done) begin
            state_q <= P_AVG_GO;
          end
        end
        P_AVG_GO: begin
          neg_q   <= p_sum[SUM_W-1];
          state_q <= P_AVG_WAIT;
        end
        P_AVG_WAIT: begin
          if (div_done) begin
            held_p_q <= signed'(q_sgn[PRESS_Q8_W-1:0]);
            state_q  <= tgood_q ? T_SCALE_GO : RESULT;
          end
        end
        T_SCALE_GO: begin
          neg_q   <= t_word[16];
          state_q <= T_SCALE_WAIT;
        end
        T_SCALE_WAIT: begin
          if (div_done) begin
            state_q <= T_AVG_GO;
          end
        end
        T_AVG_GO: begin
          neg_q   <= t_sum[SUM_W-1];
          state_q <= T_AVG_WAIT;
        end
        T_AVG_WAIT: begin
          if (div_done) begin
            held_t_q <= signed'(q_sgn[TEMP_Q8_W-1:0]);
            state_q  <= RESULT;
          end
        end
        RESULT: begin
          // Hold until the result register is free or being emptied
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= st_q;
            out_pgood_q  <= pgood_q;
            out_tgood_q  <= tgood_q;
            out_press_q  <= held_p_q;
            out_temp_q   <= held_t_q;
            state_q      <= IDLE;
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign press_crc_good_o = out_pgood_q;
  assign temp_crc_good_o  = out_tgood_q;
  assign pressure_q8_o    = out_press_q;
  assign temperature_q8_o = out_temp_q;

endmodule
